>>> src/dzsf_pkg.sv
package dzsf_pkg;

  // fixed point format
  localparam int FRAC = 16;
  localparam int FW   = 32;   // field width
  localparam int XW   = 64;   // wide working width
  localparam int PW   = 128;  // full product width

  localparam logic [XW-1:0] LIM  = (64'd1 << 62) - 64'd1;
  localparam logic [XW-1:0] ONE  = 64'd1 << FRAC;
  localparam logic [XW-1:0] K48  = (64'd48 * ONE + 64'd50) / 64'd100;
  localparam logic [XW-1:0] K235 = (64'd235 * ONE + 64'd500) / 64'd1000;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  localparam logic [CFG_IW-1:0] REG_OFFSET = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HALF   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_STIME  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MSPEED = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BEN    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BMIN   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BMAX   = 3'd6;

  localparam logic [FW-1:0] STIME_RESET  = 32'd19661;
  localparam logic [FW-1:0] MSPEED_RESET = 32'hFFFF_FFFF;

  // spring step micro-ops, run in this order
  typedef enum logic [4:0] {
    OP_OMEGA, OP_XQ, OP_X2, OP_X3, OP_T48, OP_T235, OP_E,
    OP_SQX, OP_SQY, OP_MAXC, OP_SQRT, OP_RATIO, OP_SCX, OP_SCY,
    OP_OCX, OP_TX, OP_OCY, OP_TY, OP_OTX, OP_VX, OP_OTY, OP_VY,
    OP_PX, OP_PY, OP_DOT1, OP_DOT2
  } op_t;

  typedef struct packed {
    logic load;    // latch input word
    logic goal;    // compute deadzone goal
    logic launch;  // start unit for op
    op_t  op;
    logic fin;     // commit new state
  } cmd_t;

  typedef struct packed {
    logic snap;    // smoothing off or zero step
    logic clamp;   // speed limit engages
    logic done;    // unit finished
  } sts_t;

endpackage

>>> src/dzsf_ctrl.sv
module dzsf_ctrl
  import dzsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GOAL  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   ov_r, ov_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ov_nxt    = ov_r && !out_tready;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_GOAL;
        end
      end
      ST_GOAL: begin
        cmd.goal = 1'b1;
        if (sts.snap) begin
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = OP_OMEGA;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // no speed limit: skip the rescale ops
        if (op_r == OP_RATIO && !sts.clamp) begin
          op_nxt = OP_OCX;
        end else begin
          cmd.launch = 1'b1;
          state_nxt  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.done) begin
          if (op_r == OP_DOT2) begin
            state_nxt = ST_FIN;
          end else begin
            op_nxt    = op_t'(op_r + 5'd1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_FIN: begin
        if (!ov_r || out_tready) begin
          cmd.fin   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_OMEGA;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == ST_WAIT)
    else $error("unit done outside wait");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!ov_r || out_tready))
    else $error("result word overwritten");

  a_ratio_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && op_r == OP_RATIO) |-> sts.clamp)
    else $error("rescale without speed limit");

endmodule

>>> src/dzsf_dp.sv
module dzsf_dp
  import dzsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_idx,
  input  logic [CFG_DW-1:0]        cfg_data,
  input  logic signed [FW-1:0]     target_x,
  input  logic signed [FW-1:0]     target_y,
  input  logic [FW-1:0]            time_step,
  output logic signed [FW-1:0]     pos_x,
  output logic signed [FW-1:0]     pos_y,
  output logic signed [FW-1:0]     vel_x,
  output logic signed [FW-1:0]     vel_y
);

  localparam logic signed [XW:0] LIM65  = {1'b0, LIM};
  localparam logic signed [XW:0] NLIM65 = -LIM65;
  localparam logic [2:0] MUL_LAST = 3'd4;
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [4:0] SQR_LAST = 5'd31;

  // ---------------- helpers ----------------
  function automatic logic signed [FW-1:0] sat33(input logic signed [FW:0] v);
    if (v[FW] != v[FW-1]) return v[FW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return v[FW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] sat64(input logic signed [XW-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[FW-1:0];
  endfunction

  function automatic logic signed [XW-1:0] sadd(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    if (s > LIM65) return LIM65[XW-1:0];
    if (s < NLIM65) return NLIM65[XW-1:0];
    return s[XW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] dz_goal(input logic signed [FW-1:0] d,
                                                   input logic signed [FW-1:0] p,
                                                   input logic [FW-1:0] h);
    logic signed [FW+1:0] df, hh, dd, r;
    dd = {{2{d[FW-1]}}, d};
    df = dd - {{2{p[FW-1]}}, p};
    hh = {2'b00, h};
    if (df > hh) r = dd - hh;
    else if (-df > hh) r = dd + hh;
    else r = {{2{p[FW-1]}}, p};
    return r[FW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] clampv(input logic signed [FW-1:0] v,
                                                  input logic signed [FW-1:0] lo,
                                                  input logic signed [FW-1:0] hi);
    if (v < lo) return lo;
    if (hi < v) return hi;
    return v;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_DW-1:0] off_r, half_r, bmin_r, bmax_r;
  logic [FW-1:0]     st_r, ms_r;
  logic              ben_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      half_r <= '0;
      st_r   <= STIME_RESET;
      ms_r   <= MSPEED_RESET;
      ben_r  <= 1'b0;
      bmin_r <= '0;
      bmax_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OFFSET: off_r  <= cfg_data;
        REG_HALF:   half_r <= cfg_data;
        REG_STIME:  st_r   <= cfg_data[FW-1:0];
        REG_MSPEED: ms_r   <= cfg_data[FW-1:0];
        REG_BEN:    ben_r  <= cfg_data[0];
        REG_BMIN:   bmin_r <= cfg_data;
        REG_BMAX:   bmax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- follower state ----------------
  logic signed [FW-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic                 started_r;

  // working registers
  logic signed [FW-1:0] dx_r, dy_r, gx_r, gy_r;
  logic [FW-1:0]        dt_r;
  logic signed [FW:0]   ocx_r, ocy_r;
  logic                 big_r, ovs_r;
  logic [XW-1:0]        omega_r, x_r, x2_r, x3_r, den_r, e_r, sq_r, maxc_r, r_r;
  logic [FW:0]          len_r;
  logic signed [XW-1:0] cx_r, cy_r, tx_r, ty_r, vx_r, vy_r, px_r, py_r;
  logic signed [PW:0]   dot_r;

  // offset add at input
  logic signed [FW-1:0] dxs, dys;
  assign dxs = sat33({target_x[FW-1], target_x} + {off_r[FW-1], off_r[FW-1:0]});
  assign dys = sat33({target_y[FW-1], target_y} + {off_r[CFG_DW-1], off_r[CFG_DW-1:FW]});

  // deadzone goal and change vector
  logic signed [FW-1:0] gxc, gyc;
  logic signed [FW:0]   ocxc, ocyc;
  logic [FW:0]          axc, ayc;
  assign gxc  = dz_goal(dx_r, pos_x_r, half_r[FW-1:0]);
  assign gyc  = dz_goal(dy_r, pos_y_r, half_r[CFG_DW-1:FW]);
  assign ocxc = {pos_x_r[FW-1], pos_x_r} - {gxc[FW-1], gxc};
  assign ocyc = {pos_y_r[FW-1], pos_y_r} - {gyc[FW-1], gyc};
  assign axc  = ocxc[FW] ? -ocxc : ocxc;
  assign ayc  = ocyc[FW] ? -ocyc : ocyc;

  // magnitudes for the length, halved when either is large
  logic [FW:0]   ax, ay;
  logic [FW-1:0] hx, hy;
  assign ax = ocx_r[FW] ? -ocx_r : ocx_r;
  assign ay = ocy_r[FW] ? -ocy_r : ocy_r;
  assign hx = big_r ? ax[FW:1] : ax[FW-1:0];
  assign hy = big_r ? ay[FW:1] : ay[FW-1:0];

  // status
  logic snap_c;
  assign snap_c    = (st_r == '0) || (dt_r == '0);
  assign sts.snap  = snap_c;
  assign sts.clamp = ({{(XW-FW-1){1'b0}}, len_r} > maxc_r) && (len_r != '0);

  // unit select
  logic is_div, is_sqr, mstart, dstart, sstart;
  always_comb begin
    is_div = cmd.op inside {OP_OMEGA, OP_XQ, OP_E, OP_RATIO};
    is_sqr = (cmd.op == OP_SQRT);
  end
  assign dstart = cmd.launch && is_div;
  assign sstart = cmd.launch && is_sqr;
  assign mstart = cmd.launch && !is_div && !is_sqr;

  // ---------------- multiplier operands ----------------
  logic signed [XW-1:0] sa, sb;
  logic [XW-1:0]        ma, mb;
  always_comb begin
    sa = '0;
    sb = '0;
    case (cmd.op)
      OP_X2:   begin sa = x_r;  sb = x_r; end
      OP_X3:   begin sa = x2_r; sb = x_r; end
      OP_T48:  begin sa = x2_r; sb = K48; end
      OP_T235: begin sa = x3_r; sb = K235; end
      OP_SQX:  begin sa = {32'b0, hx}; sb = {32'b0, hx}; end
      OP_SQY:  begin sa = {32'b0, hy}; sb = {32'b0, hy}; end
      OP_MAXC: begin sa = {32'b0, ms_r}; sb = {32'b0, st_r}; end
      OP_SCX:  begin sa = cx_r; sb = r_r; end
      OP_SCY:  begin sa = cy_r; sb = r_r; end
      OP_OCX:  begin sa = omega_r; sb = cx_r; end
      OP_TX:   begin sa = tx_r; sb = {32'b0, dt_r}; end
      OP_OCY:  begin sa = omega_r; sb = cy_r; end
      OP_TY:   begin sa = ty_r; sb = {32'b0, dt_r}; end
      OP_OTX:  begin sa = omega_r; sb = tx_r; end
      OP_VX:   begin sa = vx_r; sb = e_r; end
      OP_OTY:  begin sa = omega_r; sb = ty_r; end
      OP_VY:   begin sa = vy_r; sb = e_r; end
      OP_PX:   begin sa = sadd(cx_r, tx_r); sb = e_r; end
      OP_PY:   begin sa = sadd(cy_r, ty_r); sb = e_r; end
      OP_DOT1: begin
        sa = {{32{gx_r[FW-1]}}, gx_r} - px_r;
        sb = {{31{ocx_r[FW]}}, ocx_r};
      end
      OP_DOT2: begin
        sa = {{32{gy_r[FW-1]}}, gy_r} - py_r;
        sb = {{31{ocy_r[FW]}}, ocy_r};
      end
      default: ;
    endcase
  end
  assign ma = sa[XW-1] ? -sa : sa;
  assign mb = sb[XW-1] ? -sb : sb;

  // ---------------- multiplier: four 32x32 partials ----------------
  logic [XW-1:0] ma_r, mb_r, pp_r, pprod;
  logic          mneg_r, mbusy_r, mdone_r;
  logic [PW-1:0] acc_r, ppx;
  logic [2:0]    mcnt_r;
  logic [1:0]    pidx;
  logic [FW-1:0] pa, pb;

  assign pa    = mcnt_r[1] ? ma_r[XW-1:FW] : ma_r[FW-1:0];
  assign pb    = mcnt_r[0] ? mb_r[XW-1:FW] : mb_r[FW-1:0];
  assign pprod = {32'b0, pa} * {32'b0, pb};
  assign pidx  = mcnt_r[1:0] - 2'd1;

  always_comb begin
    case (pidx)
      2'd0:    ppx = {64'b0, pp_r};
      2'd3:    ppx = {pp_r, 64'b0};
      default: ppx = {32'b0, pp_r, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      mdone_r <= mbusy_r && (mcnt_r == MUL_LAST);
      if (mstart) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 3'd1;
        if (mcnt_r == MUL_LAST) mbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mstart) begin
      ma_r   <= ma;
      mb_r   <= mb;
      mneg_r <= sa[XW-1] ^ sb[XW-1];
      acc_r  <= '0;
    end else if (mbusy_r) begin
      pp_r <= pprod;
      if (mcnt_r != '0) acc_r <= acc_r + ppx;
    end
  end

  // scaled, saturated product
  logic [XW-1:0]        mag_sh;
  logic signed [XW-1:0] prod;
  logic signed [PW:0]   accs;
  logic signed [PW+1:0] dsum;
  assign mag_sh = (|acc_r[PW-1:62+FRAC]) ? LIM : {2'b00, acc_r[61+FRAC:FRAC]};
  assign prod   = mneg_r ? -mag_sh : mag_sh;
  assign accs   = mneg_r ? -{1'b0, acc_r} : {1'b0, acc_r};
  assign dsum   = {dot_r[PW], dot_r} + {accs[PW], accs};

  // ---------------- divider: restoring, one bit a cycle ----------------
  logic [XW-1:0] dnum, dden, dq_r, drem_r, dden_r;
  logic [XW:0]   dt_sh, ddiff;
  logic          dge, dbusy_r, ddone_r;
  logic [5:0]    dcnt_r;

  always_comb begin
    dnum = '0;
    dden = '0;
    case (cmd.op)
      OP_OMEGA: begin dnum = 64'd2 << (2 * FRAC); dden = {32'b0, st_r}; end
      OP_XQ:    begin dnum = {31'b0, dt_r, 1'b0} << FRAC; dden = {32'b0, st_r}; end
      OP_E:     begin dnum = (64'd1 << (2 * FRAC)) + (den_r >> 1); dden = den_r; end
      OP_RATIO: begin dnum = maxc_r << FRAC; dden = {31'b0, len_r}; end
      default: ;
    endcase
  end

  assign dt_sh = {drem_r, dq_r[XW-1]};
  assign ddiff = dt_sh - {1'b0, dden_r};
  assign dge   = (dt_sh >= {1'b0, dden_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      ddone_r <= dbusy_r && (dcnt_r == DIV_LAST);
      if (dstart) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 6'd1;
        if (dcnt_r == DIV_LAST) dbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dstart) begin
      dq_r   <= dnum;
      drem_r <= '0;
      dden_r <= dden;
    end else if (dbusy_r) begin
      drem_r <= dge ? ddiff[XW-1:0] : dt_sh[XW-1:0];
      dq_r   <= {dq_r[XW-2:0], dge};
    end
  end

  // ---------------- square root: one root bit a cycle ----------------
  logic [XW-1:0] sv_r;
  logic [33:0]   srem_r;
  logic [FW-1:0] sroot_r;
  logic [35:0]   st_sh, strial, sdiff;
  logic          sge, sbusy_r, sdone_r;
  logic [4:0]    scnt_r;

  assign st_sh  = {srem_r, sv_r[XW-1:XW-2]};
  assign strial = {2'b00, sroot_r, 2'b01};
  assign sdiff  = st_sh - strial;
  assign sge    = (st_sh >= strial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      scnt_r  <= '0;
    end else begin
      sdone_r <= sbusy_r && (scnt_r == SQR_LAST);
      if (sstart) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 5'd1;
        if (scnt_r == SQR_LAST) sbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sstart) begin
      sv_r    <= sq_r;
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (sbusy_r) begin
      sv_r    <= sv_r << 2;
      srem_r  <= sge ? sdiff[33:0] : st_sh[33:0];
      sroot_r <= {sroot_r[FW-2:0], sge};
    end
  end

  assign sts.done = mdone_r | ddone_r | sdone_r;

  // ---------------- working register updates ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= dxs;
      dy_r <= dys;
      dt_r <= time_step;
    end
    if (cmd.goal) begin
      gx_r  <= gxc;
      gy_r  <= gyc;
      ocx_r <= ocxc;
      ocy_r <= ocyc;
      cx_r  <= {{31{ocxc[FW]}}, ocxc};
      cy_r  <= {{31{ocyc[FW]}}, ocyc};
      big_r <= axc[FW] | axc[FW-1] | ayc[FW] | ayc[FW-1];
      ovs_r <= 1'b0;
    end
    if (sts.done) begin
      case (cmd.op)
        OP_OMEGA: omega_r <= dq_r;
        OP_XQ:    x_r     <= dq_r;
        OP_X2:    x2_r    <= mag_sh;
        OP_X3:    x3_r    <= mag_sh;
        OP_T48:   den_r   <= ONE + x_r + mag_sh;
        OP_T235:  den_r   <= den_r + mag_sh;
        OP_E:     e_r     <= dq_r;
        OP_SQX:   sq_r    <= acc_r[XW-1:0];
        OP_SQY:   sq_r    <= sq_r + acc_r[XW-1:0];
        OP_MAXC:  maxc_r  <= mag_sh;
        OP_SQRT:  len_r   <= big_r ? {sroot_r, 1'b0} : {1'b0, sroot_r};
        OP_RATIO: r_r     <= dq_r;
        OP_SCX:   cx_r    <= prod;
        OP_SCY:   cy_r    <= prod;
        OP_OCX:   tx_r    <= sadd({{32{vel_x_r[FW-1]}}, vel_x_r}, prod);
        OP_TX:    tx_r    <= prod;
        OP_OCY:   ty_r    <= sadd({{32{vel_y_r[FW-1]}}, vel_y_r}, prod);
        OP_TY:    ty_r    <= prod;
        OP_OTX:   vx_r    <= sadd({{32{vel_x_r[FW-1]}}, vel_x_r}, -prod);
        OP_VX:    vx_r    <= prod;
        OP_OTY:   vy_r    <= sadd({{32{vel_y_r[FW-1]}}, vel_y_r}, -prod);
        OP_VY:    vy_r    <= prod;
        OP_PX:    px_r    <= sadd({{32{pos_x_r[FW-1]}}, pos_x_r} - cx_r, prod);
        OP_PY:    py_r    <= sadd({{32{pos_y_r[FW-1]}}, pos_y_r} - cy_r, prod);
        OP_DOT1:  dot_r   <= accs;
        OP_DOT2:  ovs_r   <= !dsum[PW+1] && (dsum != '0);
        default: ;
      endcase
    end
  end

  // ---------------- commit ----------------
  logic                 zero_c;
  logic signed [FW-1:0] npx0, npy0, npx, npy, nvx, nvy;
  assign zero_c = snap_c || ovs_r;
  assign npx0   = zero_c ? gx_r : sat64(px_r);
  assign npy0   = zero_c ? gy_r : sat64(py_r);
  assign nvx    = zero_c ? '0 : sat64(vx_r);
  assign nvy    = zero_c ? '0 : sat64(vy_r);
  assign npx    = ben_r ? clampv(npx0, bmin_r[FW-1:0], bmax_r[FW-1:0]) : npx0;
  assign npy    = ben_r ? clampv(npy0, bmin_r[CFG_DW-1:FW], bmax_r[CFG_DW-1:FW]) : npy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      started_r <= 1'b0;
    end else if (cmd.load && !started_r) begin
      // first word snaps to the target
      pos_x_r   <= dxs;
      pos_y_r   <= dys;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      started_r <= 1'b1;
    end else if (cmd.fin) begin
      pos_x_r <= npx;
      pos_y_r <= npy;
      vel_x_r <= nvx;
      vel_y_r <= nvy;
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign vel_x = vel_x_r;
  assign vel_y = vel_y_r;

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mbusy_r, dbusy_r, sbusy_r}))
    else $error("two arithmetic units busy");

endmodule

>>> src/deadzone_smooth_follow_2d.sv
// A snapping word (smoothing off or zero step) goes from acceptance through the
// goal and commit states to a valid result; a spring step runs the micro-ops in
// turn, with an extra divide and two multiplies when the speed limit engages.
// A new word is taken only once the last result is committed. Units: one shared
// 1-bit-per-cycle divider, a square root and a 4-partial 32x32 multiplier.
// Reset (rst_n, synchronous): registers to defaults, follower state cleared.
module deadzone_smooth_follow_2d
  import dzsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [95:0]         in_tdata,   // target_x, target_y, time_step
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,  // pos_x, pos_y, vel_x, vel_y
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_idx,
  input  logic [CFG_DW-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic signed [FW-1:0] pos_x, pos_y, vel_x, vel_y;

  dzsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  dzsf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .target_x  (in_tdata[31:0]),
    .target_y  (in_tdata[63:32]),
    .time_step (in_tdata[95:64]),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y)
  );

  assign out_tdata = {vel_y, vel_x, pos_y, pos_x};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dzsf_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 185;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [95:0]   in_tdata;    // target_x, target_y, time_step
  logic          out_tvalid;
  logic          out_tready;
  logic [127:0]  out_tdata;   // pos_x, pos_y, vel_x, vel_y
  logic          cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  deadzone_smooth_follow_2d DUT (.*);

  typedef struct {
    logic [31:0] px, py, vx, vy;
  } follow_state_t;

  typedef struct {
    logic [31:0] tx, ty, dt;
    bit          typed;     // expected position typed in, velocity zero
    logic [31:0] ex, ey;
  } stim_row_t;

  // follower model state and register copies
  longint      fol_px, fol_py, fol_vx, fol_vy;
  bit          fol_started;
  logic [63:0] r_offset, r_half, r_bmin, r_bmax;
  logic [31:0] r_stime, r_mspeed;
  bit          r_ben;

  follow_state_t expected_q[$];
  int  send_idle_pct, recv_stall_pct;
  int  cycles;
  bit  failed;
  logic [31:0] last_tx, last_ty;

  // ---------------- fixed point helpers ----------------
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic longint unsigned umul_q(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> FRAC;
    return (p > {64'd0, LIM}) ? LIM : p[63:0];
  endfunction

  function automatic longint smul_q(longint a, longint b);
    longint unsigned m;
    m = umul_q(mag(a), mag(b));
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sadd_q(longint a, longint b);
    longint s;
    s = a + b;
    if (s > longint'(LIM)) return longint'(LIM);
    if (s < -longint'(LIM)) return -longint'(LIM);
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // exact sign of a1*b1 + a2*b2
  function automatic bit dot_pos(longint a1, longint b1, longint a2, longint b2);
    logic signed [129:0] w1, w2, w3, w4, s;
    w1 = a1; w2 = b1; w3 = a2; w4 = b2;
    s = w1 * w2 + w3 * w4;
    return s > 0;
  endfunction

  function automatic longint dz_goal(longint want, longint pos, longint half);
    longint d;
    d = want - pos;
    if (d > half) return want - half;
    if (-d > half) return want + half;
    return pos;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (hi < v) return hi;
    return v;
  endfunction

  // one follower update, advances the model state
  function automatic follow_state_t follow_step(logic [31:0] tx, logic [31:0] ty,
                                                logic [31:0] dt);
    longint dx, dy, gx, gy, omega, e, ocx, ocy, cx, cy, tmx, tmy, vx, vy, px, py, r;
    longint unsigned st, x, x2, x3, den, ax, ay, len, maxc;
    follow_state_t res;
    dx = sat32(longint'($signed(tx)) + longint'($signed(r_offset[31:0])));
    dy = sat32(longint'($signed(ty)) + longint'($signed(r_offset[63:32])));
    if (!fol_started) begin
      fol_px = dx; fol_py = dy; fol_vx = 0; fol_vy = 0;
      fol_started = 1;
    end
    gx = dz_goal(dx, fol_px, longint'({32'd0, r_half[31:0]}));
    gy = dz_goal(dy, fol_py, longint'({32'd0, r_half[63:32]}));
    if (r_stime == 0 || dt == 0) begin
      fol_px = gx; fol_py = gy; fol_vx = 0; fol_vy = 0;
    end else begin
      st    = r_stime;
      omega = longint'((64'd2 << (2 * FRAC)) / st);
      x     = ((64'd2 * dt) << FRAC) / st;
      x2    = umul_q(x, x);
      x3    = umul_q(x2, x);
      den   = ONE + x + umul_q(x2, K48) + umul_q(x3, K235);
      e     = longint'((ONE * ONE + den / 2) / den);
      ocx = fol_px - gx; ocy = fol_py - gy;
      cx = ocx; cy = ocy;
      ax = mag(cx); ay = mag(cy);
      maxc = umul_q(r_mspeed, st);
      if (ax < 64'h8000_0000 && ay < 64'h8000_0000)
        len = int_sqrt(ax * ax + ay * ay);
      else
        len = int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
      // speed limit scales the change vector
      if (len > maxc && len > 0) begin
        r  = longint'((maxc << FRAC) / len);
        cx = smul_q(cx, r);
        cy = smul_q(cy, r);
      end
      tmx = smul_q(sadd_q(fol_vx, smul_q(omega, cx)), longint'(dt));
      tmy = smul_q(sadd_q(fol_vy, smul_q(omega, cy)), longint'(dt));
      vx  = smul_q(sadd_q(fol_vx, -smul_q(omega, tmx)), e);
      vy  = smul_q(sadd_q(fol_vy, -smul_q(omega, tmy)), e);
      px  = sadd_q(fol_px - cx, smul_q(sadd_q(cx, tmx), e));
      py  = sadd_q(fol_py - cy, smul_q(sadd_q(cy, tmy), e));
      // overshoot stops at the goal
      if (dot_pos(gx - px, ocx, gy - py, ocy)) begin
        fol_px = gx; fol_py = gy; fol_vx = 0; fol_vy = 0;
      end else begin
        fol_px = sat32(px); fol_py = sat32(py);
        fol_vx = sat32(vx); fol_vy = sat32(vy);
      end
    end
    if (r_ben) begin
      fol_px = clamp_to(fol_px, longint'($signed(r_bmin[31:0])),
                        longint'($signed(r_bmax[31:0])));
      fol_py = clamp_to(fol_py, longint'($signed(r_bmin[63:32])),
                        longint'($signed(r_bmax[63:32])));
    end
    res.px = fol_px[31:0]; res.py = fol_py[31:0];
    res.vx = fol_vx[31:0]; res.vy = fol_vy[31:0];
    return res;
  endfunction

  // ---------------- clock and cycle limit ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    follow_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected word %h", $time, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.px) begin
          failed = 1;
          $display("%0t: pos_x expected %h actual %h", $time, want.px, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.py) begin
          failed = 1;
          $display("%0t: pos_y expected %h actual %h", $time, want.py, out_tdata[63:32]);
        end
        if (out_tdata[95:64] !== want.vx) begin
          failed = 1;
          $display("%0t: vel_x expected %h actual %h", $time, want.vx, out_tdata[95:64]);
        end
        if (out_tdata[127:96] !== want.vy) begin
          failed = 1;
          $display("%0t: vel_y expected %h actual %h", $time, want.vy, out_tdata[127:96]);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------- drivers ----------------
  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_OFFSET: r_offset = val;
      REG_HALF:   r_half   = val;
      REG_STIME:  r_stime  = val[31:0];
      REG_MSPEED: r_mspeed = val[31:0];
      REG_BEN:    r_ben    = val[0];
      REG_BMIN:   r_bmin   = val;
      REG_BMAX:   r_bmax   = val;
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // send one word; valid stays high after acceptance
  task automatic send_word(logic [31:0] tx, logic [31:0] ty, logic [31:0] dt,
                           bit typed, logic [31:0] ex, logic [31:0] ey);
    follow_state_t pred;
    pred = follow_step(tx, ty, dt);
    if (typed) begin
      pred.px = ex; pred.py = ey; pred.vx = 0; pred.vy = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    expected_q.push_back(pred);
    in_tvalid <= 1'b1;
    in_tdata  <= {dt, ty, tx};
    last_tx = tx; last_ty = ty;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register settings per phase, extremes on fixed phases
  task automatic set_phase(int p);
    logic [31:0] lo, hi;
    case (p % 4)
      0: cfg_write(REG_STIME, 64'd0);
      1: cfg_write(REG_STIME, 64'd1);
      2: cfg_write(REG_STIME, 64'hFFFF_FFFF);
      default: cfg_write(REG_STIME, $urandom_range(200000, 3277));
    endcase
    case (p % 3)
      0: cfg_write(REG_MSPEED, 64'hFFFF_FFFF);
      1: cfg_write(REG_MSPEED, 64'd0);
      default: cfg_write(REG_MSPEED, $urandom_range(20 << 16, 1));
    endcase
    case (p)
      2: cfg_write(REG_OFFSET, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      5: cfg_write(REG_OFFSET, {32'h8000_0000, 32'h8000_0000});
      default: cfg_write(REG_OFFSET, {$urandom_range(8 << 16), $urandom_range(8 << 16)});
    endcase
    case (p % 4)
      0: cfg_write(REG_HALF, 64'd0);
      1: cfg_write(REG_HALF, 64'hFFFF_FFFF_FFFF_FFFF);
      default: cfg_write(REG_HALF, {$urandom_range(4 << 16), $urandom_range(4 << 16)});
    endcase
    cfg_write(REG_BEN, {63'd0, p[0]});
    lo = $urandom_range(30 << 16);
    hi = $urandom_range(30 << 16);
    // phase 3 sets inverted bounds, phase 7 the full range
    if (p == 7) begin
      cfg_write(REG_BMIN, {32'h8000_0000, 32'h8000_0000});
      cfg_write(REG_BMAX, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    end else if (p == 3) begin
      cfg_write(REG_BMIN, {32'd10 << 16, 32'd10 << 16});
      cfg_write(REG_BMAX, {-32'sd10 <<< 16, -32'sd10 <<< 16});
    end else begin
      cfg_write(REG_BMIN, {-lo, -lo});
      cfg_write(REG_BMAX, {hi, hi});
    end
    cfg_close();
  endtask

  // ---------------- stimulus ----------------
  stim_row_t directed[] = '{
    '{32'h0064_0000, 32'hFFCE_0000, 32'd1092, 1, 32'h0064_0000, 32'hFFCE_0000},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0,    1, 32'h7FFF_FFFF, 32'h8000_0000},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0,    1, 32'h8000_0000, 32'h7FFF_FFFF},
    '{32'h0000_0000, 32'h0000_0000, 32'd1092, 0, 32'd0, 32'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'd0, 32'd0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1,    0, 32'd0, 32'd0},
    '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 32'd0, 32'd0},
    '{32'h000A_0000, 32'h0014_0000, 32'd1092, 0, 32'd0, 32'd0},
    '{32'h000A_0000, 32'h0014_0000, 32'd1092, 0, 32'd0, 32'd0},
    '{32'hFFF6_0000, 32'h0003_8000, 32'd546,  0, 32'd0, 32'd0},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'd65536, 0, 32'd0, 32'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'd0,    1, 32'd0, 32'd0}
  };

  initial begin
    logic [31:0] tx, ty, dt;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    cycles = 0; failed = 0; send_idle_pct = 0; recv_stall_pct = 0;
    fol_px = 0; fol_py = 0; fol_vx = 0; fol_vy = 0; fol_started = 0;
    r_offset = 0; r_half = 0; r_stime = STIME_RESET; r_mspeed = MSPEED_RESET;
    r_ben = 0; r_bmin = 0; r_bmax = 0;
    last_tx = 0; last_ty = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words with reset settings
    foreach (directed[i])
      send_word(directed[i].tx, directed[i].ty, directed[i].dt, directed[i].typed,
                directed[i].ex, directed[i].ey);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < 70) begin
          // smooth target motion at frame rate
          tx = last_tx + $urandom_range(10 << 16) - (5 << 16);
          ty = last_ty + $urandom_range(10 << 16) - (5 << 16);
          dt = ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(4000, 1);
        end else begin
          tx = $urandom;
          ty = $urandom;
          dt = $urandom;
        end
        send_word(tx, ty, dt, 0, 32'd0, 32'd0);
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (!failed) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
